@@ hdl/wavhp_pkg.sv @@
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared types and constants for the RIFF/WAVE PCM header parser: request
// payload layouts, chunk tags, accepted format values and status codes.
// ----------------------------------------------------------------------------
package wavhp_pkg;

	// chunk and container tags, big-endian byte order
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666d_7420;

	// accepted format
	localparam logic [31:0] RATE_A    = 32'd44100;
	localparam logic [31:0] RATE_B    = 32'd48000;
	localparam logic [7:0]  NEED_BITS = 8'd16;
	localparam logic [31:0] FMT_BODY  = 32'd16;

	// result status codes
	localparam logic [2:0] ST_PENDING = 3'd0;
	localparam logic [2:0] ST_AUDIO   = 3'd1;
	localparam logic [2:0] ST_NOTWAVE = 3'd2;
	localparam logic [2:0] ST_BADFMT  = 3'd3;
	localparam logic [2:0] ST_BEYOND  = 3'd4;

	// bound on the frame size, above the largest possible (255 >> 3) * 255 = 7905
	localparam logic [12:0] FRAME_MAX = 13'd8160;

	// one stream byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} byte_req_t;

	// one parser result
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  audio_byte;
		logic [31:0] sample_rate;
		logic [7:0]  channels;
		logic [7:0]  bits_per_sample;
		logic [12:0] frame_bytes;
		logic [31:0] data_size;
		logic [31:0] data_start;
	} result_req_t;

endpackage

@@ hdl/wavhp_stream_if.sv @@
// ----------------------------------------------------------------------------
// wavhp_stream_if
// Valid/ready channel carrying one request of a packed payload type.
// ----------------------------------------------------------------------------
interface wavhp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/wav_header_parser.sv @@
// ----------------------------------------------------------------------------
// wav_header_parser
// Byte-serial RIFF/WAVE PCM header parser with payload pass-through.
// ----------------------------------------------------------------------------
// The parser takes one byte request per cycle on stream and gives exactly one
// result request per byte on report, through an input register and then the
// combinational header step into the result register. It sustains one byte
// every cycle; the only limit is report back-pressure.
// Header status stays 0 until the data header is complete; then payload
// bytes come out with status 1 until the data size is used up or the stream
// ends, after which every request reports status 4. A bad tag, non-PCM fmt,
// or an end in the header gives a sticky status 2, an unsupported format a
// sticky status 3. Stream carries wavhp_pkg::byte_req_t, report result_req_t.
// ----------------------------------------------------------------------------
module wav_header_parser (
	input  logic           clk,
	input  logic           arst_n,
	wavhp_stream_if.sink   stream,
	wavhp_stream_if.source report
);
	import wavhp_pkg::*;

	typedef enum logic [3:0] {
		PH_RIFF, PH_RSIZE, PH_WAVE, PH_CHDR, PH_FMT, PH_SKIP,
		PH_DATA, PH_NOTWAVE, PH_BADFMT, PH_DONE
	} phase_t;

	// parser state
	phase_t      phase_q, phase_n;
	logic [4:0]  field_count_q, field_count_n;
	logic [31:0] word_shift_q, word_shift_n;
	logic [31:0] chunk_tag_q, chunk_tag_n;
	logic [31:0] skip_remaining_q, skip_remaining_n;
	logic [31:0] rate_q, rate_n;
	logic [7:0]  channels_q, channels_n;
	logic [7:0]  bits_q, bits_n;
	logic [12:0] frame_bytes_q, frame_bytes_n;
	logic [31:0] size_q, size_n;
	logic [31:0] file_offset_q, file_offset_n;
	logic [31:0] payload_left_q, payload_left_n;

	// pipeline registers
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        valid_s2;
	result_req_t res_s2;

	logic        adv_s1;
	logic        format_ok;
	logic        hdr_phase;
	logic [2:0]  status_n;
	logic [7:0]  audio_n;
	result_req_t res_n;

	// handshake: stage one moves on when the result register is free or is read out
	assign adv_s1       = valid_s1 && (!valid_s2 || report.ready);
	assign stream.ready = !valid_s1 || adv_s1;
	assign report.valid = valid_s2;
	assign report.payload = res_s2;

	assign format_ok = ((rate_q == RATE_A) || (rate_q == RATE_B))
		&& ((channels_q == 8'd1) || (channels_q == 8'd2))
		&& (bits_q == NEED_BITS);

	assign hdr_phase = (phase_q == PH_RIFF) || (phase_q == PH_RSIZE)
		|| (phase_q == PH_WAVE) || (phase_q == PH_CHDR)
		|| (phase_q == PH_FMT) || (phase_q == PH_SKIP);

	// one byte step of the parser
	always_comb begin
		phase_n          = phase_q;
		field_count_n    = field_count_q;
		word_shift_n     = word_shift_q;
		chunk_tag_n      = chunk_tag_q;
		skip_remaining_n = skip_remaining_q;
		rate_n           = rate_q;
		channels_n       = channels_q;
		bits_n           = bits_q;
		frame_bytes_n    = frame_bytes_q;
		size_n           = size_q;
		file_offset_n    = file_offset_q;
		payload_left_n   = payload_left_q;
		status_n         = ST_PENDING;
		audio_n          = 8'd0;

		if (hdr_phase) begin
			if (end_s1) begin
				phase_n = PH_NOTWAVE;
			end else begin
				file_offset_n = file_offset_q + 32'd1;
				unique case (phase_q)
					PH_RIFF, PH_WAVE: begin
						word_shift_n  = {word_shift_q[23:0], byte_s1};
						field_count_n = field_count_q + 5'd1;
						if (field_count_q >= 5'd3) begin
							field_count_n = 5'd0;
							if (word_shift_n != ((phase_q == PH_RIFF) ? TAG_RIFF : TAG_WAVE))
								phase_n = PH_NOTWAVE;
							else
								phase_n = (phase_q == PH_RIFF) ? PH_RSIZE : PH_CHDR;
							word_shift_n = 32'd0;
						end
					end
					PH_RSIZE: begin
						field_count_n = field_count_q + 5'd1;
						if (field_count_q >= 5'd3) begin
							field_count_n = 5'd0;
							phase_n       = PH_WAVE;
						end
					end
					PH_CHDR: begin
						if (field_count_q < 5'd4)
							chunk_tag_n = {chunk_tag_q[23:0], byte_s1};
						else
							word_shift_n = {byte_s1, word_shift_q[31:8]};
						field_count_n = field_count_q + 5'd1;
						if (field_count_q >= 5'd7) begin
							field_count_n = 5'd0;
							if (chunk_tag_n == TAG_FMT) begin
								skip_remaining_n = (word_shift_n >= FMT_BODY)
									? word_shift_n - FMT_BODY : 32'd0;
								phase_n = PH_FMT;
							end else if (chunk_tag_n == TAG_DATA) begin
								size_n         = word_shift_n;
								payload_left_n = word_shift_n;
								if (!format_ok)
									phase_n = PH_BADFMT;
								else
									phase_n = (word_shift_n != 32'd0) ? PH_DATA : PH_DONE;
							end else begin
								skip_remaining_n = word_shift_n;
								phase_n = (word_shift_n != 32'd0) ? PH_SKIP : PH_CHDR;
							end
						end
					end
					PH_FMT: begin
						if (((field_count_q == 5'd0) && (byte_s1 != 8'd1))
							|| ((field_count_q == 5'd1) && (byte_s1 != 8'd0))) begin
							phase_n       = PH_NOTWAVE;
							field_count_n = 5'd0;
						end else begin
							if (field_count_q == 5'd2)
								channels_n = byte_s1;
							if ((field_count_q >= 5'd4) && (field_count_q <= 5'd7))
								word_shift_n = {byte_s1, word_shift_q[31:8]};
							if (field_count_q == 5'd7)
								rate_n = word_shift_n;
							if (field_count_q == 5'd14) begin
								bits_n        = byte_s1;
								frame_bytes_n = 13'(byte_s1[7:3] * channels_q);
							end
							field_count_n = field_count_q + 5'd1;
							if (field_count_q >= 5'd15) begin
								field_count_n = 5'd0;
								phase_n = (skip_remaining_q != 32'd0) ? PH_SKIP : PH_CHDR;
							end
						end
					end
					default: begin
						if (skip_remaining_q != 32'd0)
							skip_remaining_n = skip_remaining_q - 32'd1;
						if (skip_remaining_n == 32'd0)
							phase_n = PH_CHDR;
					end
				endcase
			end
			if (phase_n == PH_NOTWAVE)
				status_n = ST_NOTWAVE;
			else if (phase_n == PH_BADFMT)
				status_n = ST_BADFMT;
			else
				status_n = ST_PENDING;
		end else begin
			unique case (phase_q)
				PH_DATA: begin
					if (end_s1 || (payload_left_q == 32'd0)) begin
						phase_n  = PH_DONE;
						status_n = ST_BEYOND;
					end else begin
						status_n       = ST_AUDIO;
						audio_n        = byte_s1;
						payload_left_n = payload_left_q - 32'd1;
						if (payload_left_n == 32'd0)
							phase_n = PH_DONE;
					end
				end
				PH_BADFMT: status_n = ST_BADFMT;
				PH_DONE:   status_n = ST_BEYOND;
				default: begin
					phase_n  = PH_NOTWAVE;
					status_n = ST_NOTWAVE;
				end
			endcase
		end
	end

	// result assembly
	always_comb begin
		res_n.status          = status_n;
		res_n.audio_byte      = audio_n;
		res_n.sample_rate     = rate_n;
		res_n.channels        = channels_n;
		res_n.bits_per_sample = bits_n;
		res_n.frame_bytes     = frame_bytes_n;
		res_n.data_size       = size_n;
		res_n.data_start      = ((phase_n == PH_DATA) || (phase_n == PH_BADFMT)
			|| (phase_n == PH_DONE)) ? file_offset_n : 32'd0;
	end

	// parser state and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_RIFF;
			field_count_q    <= 5'd0;
			word_shift_q     <= 32'd0;
			chunk_tag_q      <= 32'd0;
			skip_remaining_q <= 32'd0;
			rate_q           <= 32'd0;
			channels_q       <= 8'd0;
			bits_q           <= 8'd0;
			frame_bytes_q    <= 13'd0;
			size_q           <= 32'd0;
			file_offset_q    <= 32'd0;
			payload_left_q   <= 32'd0;
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
		end else begin
			if (stream.ready)
				valid_s1 <= stream.valid;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (report.ready)
				valid_s2 <= 1'b0;
			if (adv_s1) begin
				phase_q          <= phase_n;
				field_count_q    <= field_count_n;
				word_shift_q     <= word_shift_n;
				chunk_tag_q      <= chunk_tag_n;
				skip_remaining_q <= skip_remaining_n;
				rate_q           <= rate_n;
				channels_q       <= channels_n;
				bits_q           <= bits_n;
				frame_bytes_q    <= frame_bytes_n;
				size_q           <= size_n;
				file_offset_q    <= file_offset_n;
				payload_left_q   <= payload_left_n;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.payload.data_byte;
			end_s1  <= stream.payload.stream_end;
		end
		if (adv_s1)
			res_s2 <= res_n;
	end

	// end states are sticky
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("done state left");

	a_badfmt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BADFMT |=> phase_q == PH_BADFMT)
		else $error("bad format state left");

	// a held input request is not lost while the result side stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(byte_s1) && $stable(end_s1))
		else $error("stage one request lost under stall");

	// audio byte only travels with an audio status
	a_audio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.status != ST_AUDIO) |-> res_s2.audio_byte == 8'd0)
		else $error("audio byte without audio status");

	// frame size stays within what the fmt fields can give
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_bytes_q <= FRAME_MAX)
		else $error("frame size out of range");

endmodule
